// ===== rtl/bcd_pkg.sv =====
// shared constants and types for the bpsk coherent demodulator
package bcd_pkg;

   // default values of the top-level parameters
   localparam int DEF_SAMPLE_BITS       = 16;
   localparam int DEF_PHASE_BITS        = 32;
   localparam int DEF_COS_ADDR_BITS     = 10;
   localparam int DEF_MAX_SYMBOL_LENGTH = 1024;

   // fixed field widths
   localparam int COS_BITS       = 16;
   localparam int SUM_BITS       = 42;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 2;
   localparam int SYM_LEN_BITS   = 11;
   localparam int RSP_TDATA_BITS = ((1 + SUM_BITS + 7) / 8) * 8;

   // register reset values
   localparam logic [CSR_DATA_BITS-1:0] PHASE_INC_RESET = 32'h4000_0000;
   localparam logic [CSR_DATA_BITS-1:0] PHASE_OFS_RESET = 32'h0000_0000;
   localparam logic [SYM_LEN_BITS-1:0]  SYM_LEN_RESET   = 11'd8;

   // register map
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_PHASE_INC = 2'd0,
      CSR_PHASE_OFS = 2'd1,
      CSR_SYM_LEN   = 2'd2
   } csr_index_type;

endpackage

// ===== rtl/bcd_cos_rom.sv =====
// carrier cosine rom, full period, q1.15 values, registered read
module bcd_cos_rom #(
   parameter int ADDR_BITS = bcd_pkg::DEF_COS_ADDR_BITS
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [ADDR_BITS-1:0]                 rd_addr,
   output logic signed [bcd_pkg::COS_BITS-1:0]  rd_data
);
   import bcd_pkg::*;

   localparam int    DEPTH      = 1 << ADDR_BITS;
   localparam int    QUARTER    = DEPTH / 4;
   localparam longint Q30_ONE    = 64'sd1 <<< 30;
   localparam longint TWO_PI_Q30 = 64'sd6746518852;
   localparam longint HORNER_DIV [6] = '{132, 90, 56, 30, 12, 2};

   typedef logic signed [COS_BITS-1:0] cos_table_type [DEPTH];

   // taylor series to theta^12 in q30, truncating division, scaled to 32767
   function automatic longint quarter_cos(input longint m);
      longint theta;
      longint t2;
      longint r;
      theta = (m * TWO_PI_Q30) >>> ADDR_BITS;
      t2    = (theta * theta) / Q30_ONE;
      r     = Q30_ONE;
      for (int i = 0; i < 6; i++) begin
         r = Q30_ONE - ((t2 * r) / Q30_ONE) / HORNER_DIV[i];
      end
      if (r < 0) begin
         r = 0;
      end
      return ((r * 64'sd32767) + (64'sd1 <<< 29)) >>> 30;
   endfunction

   // full period from the first quadrant by symmetry
   function automatic cos_table_type build_table();
      cos_table_type tbl;
      logic [1:0]    quad;
      longint        j;
      longint        v;
      for (int k = 0; k < DEPTH; k++) begin
         quad = 2'(k >> (ADDR_BITS - 2));
         j    = longint'(k % QUARTER);
         v    = quarter_cos(quad[0] ? (QUARTER - j) : j);
         if (quad[1] ^ quad[0]) begin
            v = -v;
         end
         tbl[k] = COS_BITS'(v);
      end
      return tbl;
   endfunction

   localparam cos_table_type COS_TABLE = build_table();

   logic signed [COS_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= COS_TABLE[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bpsk_coherent_demodulator_top.sv =====
// bpsk coherent correlator demodulator, top level
//
// one passband sample per request; the local carrier comes from a phase
// accumulator that starts at phase_offset and steps by phase_increment per
// sample, looked up in a 2^COSINE_TABLE_ADDR_BITS entry cosine rom (q1.15).
// each sample times the carrier is summed, saturating at 42 bits signed, over
// symbol_length samples (0 acts as 1, values above MAX_SYMBOL_LENGTH clamp).
// at the end of a symbol one response carries the sum and the sign decision
// (1 when the sum is >= 0). a request with first_sample set reloads the phase
// from phase_offset and drops any partial symbol. a new phase_offset takes
// effect only at the next first_sample or reset.
// rate: one request per clock while req_tready is high. a request goes
// through three stages (rom address and phase update, registered rom read
// and multiply, then accumulate and decide into the output register): the
// accepting edge loads the rom data and stage 1 registers, then the stage 2
// product, then the output register, where the response sits; req_tready drops
// only when a symbol end reaches the last stage while that register still
// holds a response that has not been taken. the rom is a constant table, so
// there is no fill or clearing pass after reset.
// configuration writes are taken at any edge with csr_we high; write only
// while no request is in flight.
module bpsk_coherent_demodulator_top #(
   parameter int SAMPLE_BITS            = bcd_pkg::DEF_SAMPLE_BITS,
   parameter int PHASE_BITS             = bcd_pkg::DEF_PHASE_BITS,
   parameter int COSINE_TABLE_ADDR_BITS = bcd_pkg::DEF_COS_ADDR_BITS,
   parameter int MAX_SYMBOL_LENGTH      = bcd_pkg::DEF_MAX_SYMBOL_LENGTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // sample_value
   input  logic [0:0]                               req_tuser,  // first_sample
   // response channel
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // decided_bit, correlation_sum
   output logic [bcd_pkg::RSP_TDATA_BITS-1:0]       rsp_tdata,
   // configuration writes
   input  logic                                     csr_we,
   input  logic [bcd_pkg::CSR_ADDR_BITS-1:0]        csr_addr,
   input  logic [bcd_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);
   import bcd_pkg::*;

   localparam int CNT_BITS  = $clog2(MAX_SYMBOL_LENGTH + 1);
   localparam int LEN_BITS  = (CNT_BITS > SYM_LEN_BITS) ? CNT_BITS : SYM_LEN_BITS;
   localparam int PROD_BITS = SAMPLE_BITS + COS_BITS;

   // configuration registers
   logic [CSR_DATA_BITS-1:0] phase_inc_ff;
   logic [CSR_DATA_BITS-1:0] phase_ofs_ff;
   logic [SYM_LEN_BITS-1:0]  sym_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff <= PHASE_INC_RESET;
         phase_ofs_ff <= PHASE_OFS_RESET;
         sym_len_ff   <= SYM_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_PHASE_INC: phase_inc_ff <= csr_wdata;
            CSR_PHASE_OFS: phase_ofs_ff <= csr_wdata;
            CSR_SYM_LEN:   sym_len_ff   <= csr_wdata[SYM_LEN_BITS-1:0];
            default: ;  // index beyond the map is ignored
         endcase
      end
   end

   // pipeline advance: hold only when a symbol end meets an untaken response
   logic adv;
   logic accept;
   logic s2_emit;
   logic rsp_valid_ff;

   assign adv        = !(s2_emit && rsp_valid_ff && !rsp_tready);
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   // stage 0: pick the phase for this sample, start the rom read
   logic [PHASE_BITS-1:0]             phase_ff;
   logic [PHASE_BITS-1:0]             phase_use;
   logic [COSINE_TABLE_ADDR_BITS-1:0] rom_addr;

   assign phase_use = req_tuser[0] ? PHASE_BITS'(phase_ofs_ff) : phase_ff;
   assign rom_addr  = phase_use[PHASE_BITS-1 -: COSINE_TABLE_ADDR_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_BITS'(PHASE_OFS_RESET);
      end else if (accept) begin
         phase_ff <= phase_use + PHASE_BITS'(phase_inc_ff);
      end
   end

   logic signed [COS_BITS-1:0] cos_value;

   bcd_cos_rom #(
      .ADDR_BITS (COSINE_TABLE_ADDR_BITS)
   ) u_cos_rom (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (rom_addr),
      .rd_data (cos_value)
   );

   // stage 1: rom data arrives, multiply
   logic                          s1_valid_ff;
   logic                          s1_first_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_first_ff  <= req_tuser[0];
         s1_sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
   end

   // stage 2: accumulate and decide
   logic                        s2_valid_ff;
   logic                        s2_first_ff;
   logic signed [PROD_BITS-1:0] s2_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_first_ff <= s1_first_ff;
         s2_prod_ff  <= s1_sample_ff * cos_value;
      end
   end

   logic signed [SUM_BITS-1:0] sum_ff;
   logic [CNT_BITS-1:0]        cnt_ff;
   logic signed [SUM_BITS-1:0] sum_base;
   logic signed [SUM_BITS:0]   sum_wide;
   logic signed [SUM_BITS-1:0] sum_in;
   logic [LEN_BITS-1:0]        cnt_in;
   logic [LEN_BITS-1:0]        eff_len;

   assign sum_base = s2_first_ff ? '0 : sum_ff;
   assign sum_wide = (SUM_BITS + 1)'(sum_base) + (SUM_BITS + 1)'(s2_prod_ff);

   // saturate when the two top bits disagree
   always_comb begin
      if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         sum_in = {sum_wide[SUM_BITS], {(SUM_BITS - 1){~sum_wide[SUM_BITS]}}};
      end else begin
         sum_in = sum_wide[SUM_BITS-1:0];
      end
   end

   assign cnt_in = (s2_first_ff ? '0 : LEN_BITS'(cnt_ff)) + LEN_BITS'(1);

   // zero length acts as one, oversize clamps
   always_comb begin
      if (sym_len_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (LEN_BITS'(sym_len_ff) > LEN_BITS'(MAX_SYMBOL_LENGTH)) begin
         eff_len = LEN_BITS'(MAX_SYMBOL_LENGTH);
      end else begin
         eff_len = LEN_BITS'(sym_len_ff);
      end
   end

   assign s2_emit = s2_valid_ff && (cnt_in >= eff_len);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (adv && s2_valid_ff) begin
         sum_ff <= s2_emit ? '0 : sum_in;
         cnt_ff <= s2_emit ? '0 : CNT_BITS'(cnt_in);
      end
   end

   // output register
   logic                       rsp_bit_ff;
   logic signed [SUM_BITS-1:0] rsp_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && s2_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_emit) begin
         rsp_bit_ff <= ~sum_in[SUM_BITS-1];
         rsp_sum_ff <= sum_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'({rsp_sum_ff, rsp_bit_ff});

   // the count never rests at MAX_SYMBOL_LENGTH or beyond
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_BITS'(MAX_SYMBOL_LENGTH))
      else $error("symbol count out of range");

   // the decision follows the sign of the sum
   a_bit_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_bit_ff == ~rsp_sum_ff[SUM_BITS-1]))
      else $error("decided bit disagrees with sum sign");

   // a stall only happens with a symbol end in the last stage and a full output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !adv |-> (s2_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("pipeline stalled without cause");

   // the phase steps by the increment on every sample without a restart
   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tuser[0]) |=>
         (phase_ff == $past(phase_ff + PHASE_BITS'(phase_inc_ff))))
      else $error("carrier phase did not advance");

endmodule

// ===== test/bpsk_coherent_demodulator_top_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the bpsk coherent demodulator top level
module bpsk_coherent_demodulator_top_tb;
   import bcd_pkg::*;

   localparam int PHASE_BITS    = DEF_PHASE_BITS;
   localparam int COS_ADDR_BITS = DEF_COS_ADDR_BITS;
   localparam int MAX_SYM_LEN   = DEF_MAX_SYMBOL_LENGTH;
   localparam int ROM_SIZE      = 1 << COS_ADDR_BITS;
   localparam int REQ_BITS      = ((DEF_SAMPLE_BITS + 7) / 8) * 8;

   // index past the end of the register map, writes to it must be ignored
   localparam logic [CSR_ADDR_BITS-1:0] CSR_UNMAPPED = 2'd3;

   localparam longint Q30_ONE    = 64'sd1 <<< 30;
   localparam longint TWO_PI_Q30 = 64'sd6746518852;
   localparam longint SUM_HI     = (64'sd1 <<< (SUM_BITS - 1)) - 1;
   localparam longint SUM_LO     = -(64'sd1 <<< (SUM_BITS - 1));

   localparam int DRAIN_CYCLES = 10;      // pipeline is three deep, leave margin
   localparam int HOLD_CYCLES  = 300;     // long receiver stall for backpressure
   localparam int RANDOM_ITEMS = 60;      // the full-length symbol already holds 1024 samples
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [REQ_BITS-1:0] sample;
      logic                first;
   } sample_req_type;

   typedef struct packed {
      logic                       decided;
      logic signed [SUM_BITS-1:0] sum;
   } symbol_result_type;

   // dut ports
   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_BITS-1:0]       req_tdata  = '0;  // sample_value
   logic [0:0]                req_tuser  = '0;  // first_sample
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;        // decided_bit, correlation_sum
   logic                      csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_addr   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   // configuration as the block should hold it
   logic [CSR_DATA_BITS-1:0] cfg_increment = PHASE_INC_RESET;
   logic [CSR_DATA_BITS-1:0] cfg_offset    = PHASE_OFS_RESET;
   logic [SYM_LEN_BITS-1:0]  cfg_length    = SYM_LEN_RESET;

   // correlator state mirrored from the block
   logic [PHASE_BITS-1:0] carrier_phase = PHASE_OFS_RESET;
   int unsigned           symbol_count  = 0;
   longint                running_sum   = 0;
   int                    carrier_rom [ROM_SIZE];

   // stimulus side: phase used to shape bpsk symbols, tracked like the carrier
   logic [PHASE_BITS-1:0] gen_phase = '0;

   sample_req_type    pending_samples[$];
   symbol_result_type expected_symbols[$];
   sample_req_type    req_next;
   symbol_result_type rsp_want;

   int          req_gap       = 0;
   int          rsp_stall     = 0;
   int          hold_left     = 0;
   bit          hold_done     = 1'b0;
   bit          pressure_on   = 1'b0;
   int          req_idle_pct  = 0;
   int          rsp_idle_pct  = 0;
   int          error_count   = 0;
   int unsigned offered_count = 0;
   int unsigned cycle_count   = 0;

   bpsk_coherent_demodulator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // first-quadrant cosine in q1.15: taylor series to theta^12 by horner's
   // rule in q30, truncating divisions, negative clamped to zero
   function automatic int quarter_wave(int m);
      longint theta, t2, r;
      theta = (longint'(m) * TWO_PI_Q30) >>> COS_ADDR_BITS;
      t2    = (theta * theta) / Q30_ONE;
      r     = Q30_ONE;
      // divisors 12*11, 10*9, ... 2*1
      for (int i = 0; i < 6; i++) begin
         r = Q30_ONE - ((t2 * r) / Q30_ONE) / longint'((12 - 2 * i) * (11 - 2 * i));
      end
      if (r < 0) begin
         r = 0;
      end
      return int'((r * 32767 + (64'sd1 <<< 29)) >>> 30);
   endfunction

   // full-circle cosine folded onto the first quadrant
   function automatic int carrier_value(int k);
      int nq, j;
      nq = ROM_SIZE / 4;
      j  = k % nq;
      case (k / nq)
         0: return quarter_wave(j);
         1: return -quarter_wave(nq - j);
         2: return -quarter_wave(j);
         default: return quarter_wave(nq - j);
      endcase
   endfunction

   // samples per symbol: zero acts as one, oversize clamps to the maximum
   function automatic int symbol_span();
      if (cfg_length == 0) begin
         return 1;
      end
      if (cfg_length > MAX_SYM_LEN) begin
         return MAX_SYM_LEN;
      end
      return int'(cfg_length);
   endfunction

   // one multiply-accumulate step; queues a decision at each symbol end
   function automatic void correlate_sample(logic [REQ_BITS-1:0] sample, logic first);
      longint total;
      if (first) begin
         carrier_phase = cfg_offset;
         symbol_count  = 0;
         running_sum   = 0;
      end
      total = running_sum + longint'($signed(sample))
              * longint'(carrier_rom[carrier_phase[PHASE_BITS-1 -: COS_ADDR_BITS]]);
      if (total > SUM_HI) begin
         total = SUM_HI;
      end
      if (total < SUM_LO) begin
         total = SUM_LO;
      end
      running_sum   = total;
      carrier_phase = carrier_phase + cfg_increment;
      symbol_count++;
      if (symbol_count >= symbol_span()) begin
         expected_symbols.insert(expected_symbols.size(),
                                 symbol_result_type'{decided: running_sum >= 0,
                                                     sum: running_sum[SUM_BITS-1:0]});
         symbol_count = 0;
         running_sum  = 0;
      end
   endfunction

   // request driver: holds each request until taken, random idle bursts between
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            correlate_sample(req_tdata, req_tuser[0]);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_next = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= req_next.sample;
               req_tuser  <= req_next.first;
               if (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct) begin
                  req_gap = $urandom_range(1, 5);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks each response against the oldest decision due,
   // and stalls at random or for one long stretch while pressure is on
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_symbols.size() == 0) begin
               $display("%0t: response with none due, actual %h", $time, rsp_tdata);
               error_count++;
            end else begin
               rsp_want = expected_symbols.pop_front();
               if (rsp_tdata[0] !== rsp_want.decided) begin
                  $display("%0t: decided_bit expected %b actual %b",
                           $time, rsp_want.decided, rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[SUM_BITS:1] !== rsp_want.sum) begin
                  $display("%0t: correlation_sum expected %0d actual %0d", $time,
                           rsp_want.sum, $signed(rsp_tdata[SUM_BITS:1]));
                  error_count++;
               end
            end
         end
         if (pressure_on && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_idle_pct > 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
               rsp_stall = $urandom_range(1, 5);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // all requests taken and all decisions in, then let the pipe empty out
   task automatic wait_idle();
      while (pending_samples.size() > 0 || req_tvalid || expected_symbols.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_PHASE_INC: cfg_increment = value;
         CSR_PHASE_OFS: cfg_offset    = value;
         CSR_SYM_LEN:   cfg_length    = value[SYM_LEN_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic offer_sample(input logic [REQ_BITS-1:0] value, input logic first);
      pending_samples.insert(pending_samples.size(),
                             sample_req_type'{sample: value, first: first});
      gen_phase = gen_phase + cfg_increment;
      offered_count++;
   endtask

   // one symbol of n samples: a scaled carrier of random sign plus noise,
   // or plain random samples
   task automatic offer_symbol(input int n, input logic first, input logic shaped);
      longint      level, value;
      longint      noise;
      logic [31:0] rnd;
      level = $urandom_range(0, 32767);
      noise = $urandom_range(0, 3000);
      if ($urandom_range(0, 1) == 1) begin
         level = -level;
      end
      if (first) begin
         gen_phase = cfg_offset;
      end
      for (int i = 0; i < n; i++) begin
         rnd = $urandom();
         if (shaped) begin
            value = ((level * carrier_rom[gen_phase[PHASE_BITS-1 -: COS_ADDR_BITS]]) >>> 15)
                    + longint'($urandom_range(0, 2 * noise)) - noise;
            if (value > 32767) begin
               value = 32767;
            end
            if (value < -32768) begin
               value = -32768;
            end
            rnd[15:0] = value[15:0];
         end
         offer_sample(rnd[REQ_BITS-1:0], first && i == 0);
      end
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] pick_phase(bit as_step);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return as_step ? 32'h4000_0000 : 32'h8000_0000;
         3: return $urandom_range(1, 64) << 22;  // whole rom steps
         default: return $urandom();
      endcase
   endfunction

   function automatic int pick_idle();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 15;
         default: return 40;
      endcase
   endfunction

   initial begin
      int unsigned              start_count;
      int                       span, nsym, cut;
      logic [CSR_DATA_BITS-1:0] len_word;

      for (int k = 0; k < ROM_SIZE; k++) begin
         carrier_rom[k] = carrier_value(k);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset settings: step of a quarter turn, length 8
      // full-scale samples land on the carrier peaks and zeros
      offer_sample(16'h7FFF, 1'b1);
      offer_sample(16'h8000, 1'b0);
      offer_sample(16'h7FFF, 1'b0);
      offer_sample(16'h8000, 1'b0);
      offer_sample(16'h0000, 1'b0);
      offer_sample(16'h0001, 1'b0);
      offer_sample(16'hFFFF, 1'b0);
      offer_sample(16'h7FFF, 1'b0);
      wait_idle();
      write_csr(CSR_SYM_LEN, 32'd2);
      // a partial symbol is dropped by the restart that follows it
      offer_sample(16'h1234, 1'b0);
      offer_sample(16'h8000, 1'b1);
      offer_sample(16'h7FFF, 1'b0);
      wait_idle();
      write_csr(CSR_PHASE_OFS, 32'h8000_0000);
      // the new offset only applies from the next restart on
      offer_sample(16'h4000, 1'b0);
      offer_sample(16'hC000, 1'b0);
      offer_sample(16'h4000, 1'b1);
      offer_sample(16'hC000, 1'b0);
      wait_idle();
      write_csr(CSR_SYM_LEN, 32'd4);
      offer_sample(16'h2000, 1'b1);
      offer_sample(16'hE000, 1'b0);
      offer_sample(16'h5555, 1'b0);
      wait_idle();
      // shorter length mid-symbol: the count already passed it, next sample ends
      write_csr(CSR_SYM_LEN, 32'd2);
      offer_sample(16'hAAAA, 1'b0);
      wait_idle();
      write_csr(CSR_SYM_LEN, 32'd0);
      write_csr(CSR_UNMAPPED, 32'hFFFF_FFFF);
      // zero length: every sample closes a symbol
      offer_sample(16'h8001, 1'b1);
      offer_sample(16'h7FFE, 1'b0);
      wait_idle();

      // backpressure: one-sample symbols, no gaps, receiver holds off long
      write_csr(CSR_SYM_LEN, 32'd1);
      for (int i = 0; i < 40; i++) begin
         offer_sample(16'($urandom()), i == 0);
      end
      pressure_on = 1'b1;
      wait_idle();

      // oversize length clamps to the maximum: one full-length symbol
      req_idle_pct = 15;
      rsp_idle_pct = 15;
      write_csr(CSR_PHASE_INC, $urandom());
      write_csr(CSR_SYM_LEN, 32'd2047);
      offer_symbol(symbol_span(), 1'b1, 1'b1);
      wait_idle();

      // random phases of mostly well-formed symbols under random settings
      start_count = offered_count;
      while (offered_count - start_count < RANDOM_ITEMS) begin
         wait_idle();
         if (offered_count - start_count > RANDOM_ITEMS - 30) begin
            // closing stretch runs without idling on either side
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = pick_idle();
            rsp_idle_pct = pick_idle();
         end
         write_csr(CSR_PHASE_INC, pick_phase(1'b1));
         write_csr(CSR_PHASE_OFS, pick_phase(1'b0));
         case ($urandom_range(0, 11))
            0: len_word = 32'd0;
            1: len_word = $urandom_range(17, 64);
            default: len_word = $urandom_range(1, 16);
         endcase
         // stray upper bits beyond the length field are ignored
         if ($urandom_range(0, 7) == 0) begin
            len_word[CSR_DATA_BITS-1:SYM_LEN_BITS] = $urandom();
         end
         write_csr(CSR_SYM_LEN, len_word);
         span = symbol_span();
         nsym = $urandom_range(1, 6);
         for (int s = 0; s < nsym; s++) begin
            if (span > 1 && $urandom_range(0, 9) == 0) begin
               // broken sequence: partial symbol, then a restart
               cut = $urandom_range(1, span - 1);
               offer_symbol(cut, s == 0, 1'b0);
               offer_symbol(span, 1'b1, 1'b1);
            end else begin
               offer_symbol(span, s == 0, $urandom_range(0, 3) != 0);
            end
         end
         // sometimes leave a tail that the next phase's restart drops
         if (span > 1 && $urandom_range(0, 4) == 0) begin
            offer_symbol($urandom_range(1, span - 1), 1'b0, 1'b1);
         end
      end
      wait_idle();

      if (error_count == 0 && expected_symbols.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
